FILE: design/flpd_pkg.sv
// Shared types and constants for the fixed-length packet deframer.
package flpd_pkg;

    localparam int BYTE_W        = 8;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int PATTERN_BYTES = 4;
    localparam int MARKER_LEN_W  = 3;
    localparam int PKT_LEN_W     = 6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_PATTERN = 3'd0,
        REG_START_LENGTH  = 3'd1,
        REG_STOP_PATTERN  = 3'd2,
        REG_STOP_LENGTH   = 3'd3,
        REG_PACKET_LENGTH = 3'd4
    } cfg_index_t;

    localparam logic [MARKER_LEN_W-1:0] START_LENGTH_RESET  = 3'd1;
    localparam logic [MARKER_LEN_W-1:0] STOP_LENGTH_RESET   = 3'd1;
    localparam logic [PKT_LEN_W-1:0]    PACKET_LENGTH_RESET = 6'd32;

    typedef struct packed {
        logic [CFG_DATA_W-1:0]   start_pattern;
        logic [MARKER_LEN_W-1:0] start_length;
        logic [CFG_DATA_W-1:0]   stop_pattern;
        logic [MARKER_LEN_W-1:0] stop_length;
        logic [PKT_LEN_W-1:0]    packet_length;
    } cfg_t;

    typedef struct packed {
        logic hunt;
        logic take;
        logic src_feed;
        logic rd_issue;
        logic err_issue;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hunt_match;
        logic frame_end;
        logic frame_good;
        logic feed_last;
        logic fetch_free;
        logic rd_last;
    } dp_status_t;

endpackage

FILE: design/fixed_length_packet_deframer_top.sv
// Top level of the fixed-length packet deframer: configuration registers and module wiring.
// While hunting or inside a packet, one received byte is taken per cycle.
// A start match stalls the input while the start marker is copied into the packet store.
// A good packet stalls the input while its bytes are read out, one beat per cycle unless
// the receiver stalls; a bad packet stalls it while a single error beat is issued. After the
// completing byte, the first result beat passes the state, fetch and output registers. Reset is
// asynchronous and active low; it returns to hunting and restores register defaults.
module fixed_length_packet_deframer_top import flpd_pkg::*;
#(
    parameter int MAX_PACKET = 32,
    parameter int MAX_MARKER = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [BYTE_W-1:0]      rx_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [BYTE_W-1:0]      out_byte,
    output logic                   last_byte,
    output logic                   frame_error,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t       cfg_reg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_pattern <= '0;
            cfg_reg.start_length  <= START_LENGTH_RESET;
            cfg_reg.stop_pattern  <= '0;
            cfg_reg.stop_length   <= STOP_LENGTH_RESET;
            cfg_reg.packet_length <= PACKET_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_START_PATTERN: cfg_reg.start_pattern <= cfg_data;
                REG_START_LENGTH:  cfg_reg.start_length  <= cfg_data[MARKER_LEN_W-1:0];
                REG_STOP_PATTERN:  cfg_reg.stop_pattern  <= cfg_data;
                REG_STOP_LENGTH:   cfg_reg.stop_length   <= cfg_data[MARKER_LEN_W-1:0];
                REG_PACKET_LENGTH: cfg_reg.packet_length <= cfg_data[PKT_LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    flpd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    flpd_datapath
    #(
        .MAX_PACKET (MAX_PACKET),
        .MAX_MARKER (MAX_MARKER)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .rx_byte     (rx_byte),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_byte   (last_byte),
        .frame_error (frame_error)
    );

endmodule

FILE: design/flpd_datapath.sv
// Datapath: start and stop windows, packet store, burst read-out and output register.
module flpd_datapath import flpd_pkg::*;
#(
    parameter int MAX_PACKET = 32,
    parameter int MAX_MARKER = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  ctrl_cmd_t         cmd,
    input  logic [BYTE_W-1:0] rx_byte,
    output dp_status_t        status,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last_byte,
    output logic              frame_error
);

    localparam int AW    = $clog2(MAX_PACKET);
    localparam int PL_W  = $clog2(MAX_PACKET + 1);
    localparam int ML_W  = $clog2(MAX_MARKER + 1);
    localparam int CW    = (ML_W > MARKER_LEN_W) ? ML_W : MARKER_LEN_W;
    localparam int IW    = (MAX_MARKER > 1) ? $clog2(MAX_MARKER) : 1;
    localparam int FW    = (PL_W > PKT_LEN_W) ? PL_W : PKT_LEN_W;
    localparam int WIN_W = BYTE_W * MAX_MARKER;

    logic [WIN_W-1:0]  start_win_reg;
    logic [ML_W-1:0]   fill_reg;
    logic [WIN_W-1:0]  stop_win_reg;
    logic [PL_W-1:0]   held_reg;
    logic              early_reg;
    logic [IW-1:0]     feed_idx_reg;
    logic [AW-1:0]     rd_idx_reg;
    logic [BYTE_W-1:0] store_mem [MAX_PACKET];
    logic [BYTE_W-1:0] mem_rdata_reg;
    logic              fetch_valid_reg;
    logic              fetch_last_reg;
    logic              fetch_err_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic              out_err_reg;

    logic [CW-1:0]     sl;
    logic [CW-1:0]     tl;
    logic [CW-1:0]     lo;
    logic [FW-1:0]     len_full;
    logic [PL_W-1:0]   len;
    logic [WIN_W-1:0]  hunt_win_next;
    logic [ML_W-1:0]   fill_next;
    logic [IW-1:0]     feed_sel;
    logic [BYTE_W-1:0] take_byte;
    logic [WIN_W-1:0]  stop_win_next;
    logic [PL_W-1:0]   held_inc;
    logic              hunt_cmp;
    logic              stop_cmp;
    logic              stop_match;
    logic              fetch_move;

    logic [BYTE_W-1:0] win_b       [MAX_MARKER];
    logic [BYTE_W-1:0] hunt_b      [MAX_MARKER];
    logic [BYTE_W-1:0] stop_b      [MAX_MARKER];
    logic [BYTE_W-1:0] start_pat_b [MAX_MARKER];
    logic [BYTE_W-1:0] stop_pat_b  [MAX_MARKER];

    function automatic logic [CW-1:0] marker_len(input logic [MARKER_LEN_W-1:0] v);
        logic [CW-1:0] raw;
        raw = CW'(v);
        if (raw == '0)
        begin
            return CW'(1);
        end
        if (raw > CW'(MAX_MARKER))
        begin
            return CW'(MAX_MARKER);
        end
        return raw;
    endfunction

    assign sl = marker_len(cfg.start_length);
    assign tl = marker_len(cfg.stop_length);
    assign lo = (sl > tl) ? sl : tl;

    always_comb
    begin
        len_full = FW'(cfg.packet_length);
        if (len_full < FW'(lo))
        begin
            len_full = FW'(lo);
        end
        if (len_full > FW'(MAX_PACKET))
        begin
            len_full = FW'(MAX_PACKET);
        end
    end

    assign len = PL_W'(len_full);

    assign hunt_win_next = WIN_W'({start_win_reg, rx_byte});
    assign fill_next     = (fill_reg == ML_W'(MAX_MARKER)) ? fill_reg : fill_reg + ML_W'(1);
    assign feed_sel      = IW'(sl - CW'(1) - CW'(feed_idx_reg));
    assign take_byte     = cmd.src_feed ? win_b[feed_sel] : rx_byte;
    assign stop_win_next = WIN_W'({stop_win_reg, take_byte});
    assign held_inc      = held_reg + PL_W'(1);

    for (genvar g = 0; g < MAX_MARKER; g++)
    begin : g_bytes
        assign win_b[g]  = start_win_reg[BYTE_W*g +: BYTE_W];
        assign hunt_b[g] = hunt_win_next[BYTE_W*g +: BYTE_W];
        assign stop_b[g] = stop_win_next[BYTE_W*g +: BYTE_W];
        if (g < PATTERN_BYTES)
        begin : g_pat
            assign start_pat_b[g] = cfg.start_pattern[BYTE_W*g +: BYTE_W];
            assign stop_pat_b[g]  = cfg.stop_pattern[BYTE_W*g +: BYTE_W];
        end
        else
        begin : g_zero
            assign start_pat_b[g] = '0;
            assign stop_pat_b[g]  = '0;
        end
    end

    // Pattern byte j lines up with the window byte that arrived n-1-j beats ago.
    always_comb
    begin
        logic [CW-1:0] s_idx;
        logic [CW-1:0] t_idx;
        hunt_cmp = 1'b1;
        stop_cmp = 1'b1;
        for (int j = 0; j < MAX_MARKER; j++)
        begin
            s_idx = sl - CW'(1) - CW'(j);
            t_idx = tl - CW'(1) - CW'(j);
            if (CW'(j) < sl)
            begin
                if (hunt_b[s_idx[IW-1:0]] != start_pat_b[j])
                begin
                    hunt_cmp = 1'b0;
                end
            end
            if (CW'(j) < tl)
            begin
                if (stop_b[t_idx[IW-1:0]] != stop_pat_b[j])
                begin
                    stop_cmp = 1'b0;
                end
            end
        end
    end

    assign stop_match = (FW'(held_inc) >= FW'(tl)) && stop_cmp;
    assign fetch_move = fetch_valid_reg && (!out_valid_reg || !out_stall);

    assign status.hunt_match = (CW'(fill_next) >= sl) && hunt_cmp;
    assign status.frame_end  = (FW'(held_inc) >= len_full);
    assign status.frame_good = !early_reg && stop_match && (held_inc == len);
    assign status.feed_last  = (CW'(feed_idx_reg) == sl - CW'(1));
    assign status.fetch_free = !fetch_valid_reg || fetch_move;
    assign status.rd_last    = (PL_W'(rd_idx_reg) + PL_W'(1) == len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_win_reg   <= '0;
            fill_reg        <= '0;
            stop_win_reg    <= '0;
            held_reg        <= '0;
            early_reg       <= 1'b0;
            feed_idx_reg    <= '0;
            rd_idx_reg      <= '0;
            fetch_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.hunt)
            begin
                start_win_reg <= hunt_win_next;
                fill_reg      <= fill_next;
                if (status.hunt_match)
                begin
                    held_reg     <= '0;
                    stop_win_reg <= '0;
                    early_reg    <= 1'b0;
                    feed_idx_reg <= '0;
                end
            end
            if (cmd.take)
            begin
                if (status.frame_end)
                begin
                    start_win_reg <= '0;
                    fill_reg      <= '0;
                    stop_win_reg  <= '0;
                    held_reg      <= '0;
                    early_reg     <= 1'b0;
                    rd_idx_reg    <= '0;
                end
                else
                begin
                    held_reg     <= held_inc;
                    stop_win_reg <= stop_win_next;
                    if (stop_match)
                    begin
                        early_reg <= 1'b1;
                    end
                    if (cmd.src_feed)
                    begin
                        feed_idx_reg <= feed_idx_reg + IW'(1);
                    end
                end
            end
            if (cmd.rd_issue)
            begin
                rd_idx_reg <= rd_idx_reg + AW'(1);
            end
            if (cmd.rd_issue || cmd.err_issue)
            begin
                fetch_valid_reg <= 1'b1;
            end
            else if (fetch_move)
            begin
                fetch_valid_reg <= 1'b0;
            end
            if (fetch_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            store_mem[held_reg[AW-1:0]] <= take_byte;
        end
        if (cmd.rd_issue)
        begin
            mem_rdata_reg <= store_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue || cmd.err_issue)
        begin
            fetch_last_reg <= cmd.err_issue || status.rd_last;
            fetch_err_reg  <= cmd.err_issue;
        end
        if (fetch_move)
        begin
            out_byte_reg <= fetch_err_reg ? '0 : mem_rdata_reg;
            out_last_reg <= fetch_last_reg;
            out_err_reg  <= fetch_err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_byte   = out_last_reg;
    assign frame_error = out_err_reg;

`ifndef SYNTHESIS
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg < PL_W'(MAX_PACKET))
        else $error("Packet byte count has reached the store depth.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (fetch_valid_reg && !fetch_move) |-> !(cmd.rd_issue || cmd.err_issue))
        else $error("A read-out beat was issued over a held fetch beat.");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && status.frame_end) |=> (held_reg == '0 && !early_reg))
        else $error("Packet state was not cleared at the end of a packet.");
`endif

endmodule

FILE: design/flpd_ctrl.sv
// Controller: sequences hunting, start-byte replay, packet read-out and error beats.
module flpd_ctrl import flpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED,
        S_EMIT,
        S_ERROR
    } state_t;

    state_t state_reg;
    logic   in_packet_reg;
    logic   in_accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    cmd.take = in_packet_reg;
                    cmd.hunt = !in_packet_reg;
                end
            end
            S_FEED:
            begin
                cmd.take     = 1'b1;
                cmd.src_feed = 1'b1;
            end
            S_EMIT:
            begin
                cmd.rd_issue = status.fetch_free;
            end
            S_ERROR:
            begin
                cmd.err_issue = status.fetch_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_packet_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.take && status.frame_end)
                    begin
                        in_packet_reg <= 1'b0;
                        state_reg     <= status.frame_good ? S_EMIT : S_ERROR;
                    end
                    else if (cmd.hunt && status.hunt_match)
                    begin
                        in_packet_reg <= 1'b1;
                        state_reg     <= S_FEED;
                    end
                end
                S_FEED:
                begin
                    if (status.frame_end)
                    begin
                        in_packet_reg <= 1'b0;
                        state_reg     <= status.frame_good ? S_EMIT : S_ERROR;
                    end
                    else if (status.feed_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (status.fetch_free && status.rd_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_ERROR:
                begin
                    if (status.fetch_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_feed_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FEED) |-> in_packet_reg)
        else $error("Start bytes are being replayed outside a packet.");

    a_issue_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_issue || cmd.err_issue) |-> status.fetch_free)
        else $error("A result beat was issued while the fetch stage was occupied.");

    a_good_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && status.frame_end && status.frame_good) |=> (state_reg == S_EMIT))
        else $error("A good packet did not start its read-out.");
`endif

endmodule
